[hw/rtl/mtc_pkg.sv]
package mtc_pkg;

  localparam int unsigned NumCodes   = 36;
  localparam int unsigned SymMax     = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChDash  = "-";
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLowA  = "a";
  localparam logic [7:0] ChLowZ  = "z";
  localparam logic [7:0] CaseGap = 8'h20;

  // Expansion job for the back end: optional slash, symbols, final character.
  typedef struct packed {
    logic       slash;
    logic [2:0] len;
    logic [4:0] bits;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [4:0] sym;
    logic [2:0] len;
    logic       invalid;
    logic       slash;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] bits;
  } enc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } dec_t;

  localparam logic [7:0] CodeCh [NumCodes] = '{
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L",
    "M", "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X",
    "Y", "Z", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
  };

  localparam logic [2:0] CodeLen [NumCodes] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] CodeBits [NumCodes] = '{
    5'd1,  5'd8,  5'd10, 5'd4,  5'd0,  5'd2,  5'd6,  5'd0,  5'd0,  5'd7,  5'd5,  5'd4,
    5'd3,  5'd2,  5'd7,  5'd6,  5'd13, 5'd2,  5'd0,  5'd1,  5'd1,  5'd1,  5'd3,  5'd9,
    5'd11, 5'd12, 5'd31, 5'd15, 5'd7,  5'd3,  5'd1,  5'd0,  5'd16, 5'd24, 5'd28, 5'd30
  };

  function automatic logic is_white(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic enc_t encode_lookup(logic [7:0] c);
    enc_t r;
    r = '0;
    for (int i = 0; i < NumCodes; i++) begin
      if (CodeCh[i] == c) begin
        r.hit  = 1'b1;
        r.len  = CodeLen[i];
        r.bits = CodeBits[i];
      end
    end
    return r;
  endfunction

  function automatic dec_t decode_lookup(logic [2:0] len, logic [4:0] sym);
    dec_t r;
    r = '0;
    for (int i = 0; i < NumCodes; i++) begin
      if (CodeLen[i] == len && CodeBits[i] == sym) begin
        r.hit = 1'b1;
        r.ch  = CodeCh[i];
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/mtc_if.sv]
interface mtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_message;

  modport source (output valid, output in_char, output end_of_message, input ready);
  modport sink (input valid, input in_char, input end_of_message, output ready);
endinterface

interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

interface mtc_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

[hw/rtl/morse_text_codec_core.sv]
// Morse text codec.
// in_i carries one ASCII byte per transfer with an end_of_message flag; out_o
// carries one output byte per transfer, last marking the final byte that an
// input byte caused. cfg_i writes the direction: 0 encodes text to dots and
// dashes, 1 decodes Morse tokens back to characters. Write it only while idle.
// Encoding a letter or digit gives its symbols and a space; a space gives
// "/ "; other bytes give nothing. Decoding collects a token until whitespace
// or the end mark and then gives at most one character.
// An input transfer writes its job into the queue; the expander then loads it
// into its registers, and the first output byte of the item is valid from
// them. The output expander sends one byte per cycle while out_o.ready is
// high, and an item yields 1 to 6 bytes (six for a digit). The expander loads
// the next job as the last byte of the previous one transfers.
// A two-entry job queue lets input be taken while output stalls; in_i.ready
// drops only when the queue is full. A stalled output holds its byte.
// Reset clears the direction to encode, the pending token and the queue.
module morse_text_codec_core #(
  parameter int unsigned QueueDepth = mtc_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtc_in_if.sink    in_i,
  mtc_out_if.source out_o,
  mtc_cfg_if.sink   cfg_i
);

  logic          direction_q;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  mtc_pkg::cmd_t push_cmd;
  mtc_pkg::cmd_t head_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_i.valid) begin
      direction_q <= cfg_i.direction;
    end
  end

  mtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_char_i   (in_i.in_char),
    .eom_i       (in_i.end_of_message),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  mtc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  mtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.last)
  );

  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) push |-> !full
  ) else $error("job pushed into full queue");

  a_burst_continues: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_o.valid && !out_o.last |=> out_o.valid
  ) else $error("output burst ended before its last byte");

  a_space_queued: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      in_i.valid && in_i.ready && !direction_q && in_i.in_char == mtc_pkg::ChSpace
      |=> !empty || out_o.valid
  ) else $error("encoded space produced no job");

  a_pop_needs_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |-> !empty
  ) else $error("pop from empty queue");

endmodule

[hw/rtl/mtc_front.sv]
module mtc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               direction_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_char_i,
  input  logic               eom_i,
  input  logic               full_i,
  output logic               push_o,
  output mtc_pkg::cmd_t      cmd_o
);

  mtc_pkg::token_t tok_q, tok_d;

  function automatic mtc_pkg::token_t absorb(mtc_pkg::token_t t, logic [7:0] c);
    mtc_pkg::token_t r;
    r = t;
    if (c == mtc_pkg::ChDot || c == mtc_pkg::ChDash) begin
      if (t.slash || t.len >= 3'(mtc_pkg::SymMax)) begin
        r.invalid = 1'b1;
      end else begin
        r.sym = {t.sym[3:0], c == mtc_pkg::ChDash};
        r.len = t.len + 3'd1;
      end
    end else if (c == mtc_pkg::ChSlash && t.len == 3'd0 && !t.slash && !t.invalid) begin
      r.slash = 1'b1;
    end else begin
      r.invalid = 1'b1;
    end
    return r;
  endfunction

  function automatic mtc_pkg::dec_t close_token(mtc_pkg::token_t t);
    mtc_pkg::dec_t r;
    r = '0;
    if (!t.invalid) begin
      if (t.slash) begin
        r.hit = 1'b1;
        r.ch  = mtc_pkg::ChSpace;
      end else if (t.len != 3'd0) begin
        r = mtc_pkg::decode_lookup(t.len, t.sym);
      end
    end
    return r;
  endfunction

  logic            accept;
  logic [7:0]      upper;
  mtc_pkg::enc_t   enc;
  mtc_pkg::dec_t   dec;
  mtc_pkg::token_t tok_work;
  logic            closing;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    upper = (in_char_i >= mtc_pkg::ChLowA && in_char_i <= mtc_pkg::ChLowZ)
            ? in_char_i - mtc_pkg::CaseGap : in_char_i;
    enc      = mtc_pkg::encode_lookup(upper);
    tok_work = mtc_pkg::is_white(in_char_i) ? tok_q : absorb(tok_q, in_char_i);
    closing  = mtc_pkg::is_white(in_char_i) || eom_i;
    dec      = close_token(tok_work);

    tok_d  = tok_q;
    push_o = 1'b0;
    cmd_o  = '0;
    cmd_o.ch = mtc_pkg::ChSpace;

    if (!direction_i) begin
      if (upper == mtc_pkg::ChSpace) begin
        push_o      = accept;
        cmd_o.slash = 1'b1;
      end else if (enc.hit) begin
        push_o     = accept;
        cmd_o.len  = enc.len;
        cmd_o.bits = 5'(enc.bits << (3'(mtc_pkg::SymMax) - enc.len));
      end
    end else begin
      if (closing) begin
        push_o   = accept && dec.hit;
        cmd_o.ch = dec.ch;
      end
      if (accept) begin
        tok_d = closing ? '0 : tok_work;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

[hw/rtl/mtc_queue.sv]
module mtc_queue #(
  parameter int unsigned Depth = mtc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mtc_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mtc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/mtc_back.sv]
module mtc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  mtc_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          out_last_o
);

  logic       busy_q, busy_d;
  logic       slash_q, slash_d;
  logic [2:0] len_q, len_d;
  logic [4:0] bits_q, bits_d;
  logic [7:0] ch_q, ch_d;
  logic       fire;
  logic       final_beat;

  always_comb begin
    final_beat  = !slash_q && (len_q == 3'd0);
    out_valid_o = busy_q;
    out_last_o  = final_beat;
    priority if (slash_q) begin
      out_char_o = mtc_pkg::ChSlash;
    end else if (len_q != 3'd0) begin
      out_char_o = bits_q[4] ? mtc_pkg::ChDash : mtc_pkg::ChDot;
    end else begin
      out_char_o = ch_q;
    end

    fire  = busy_q && out_ready_i;
    pop_o = !empty_i && (!busy_q || (fire && final_beat));

    busy_d  = busy_q;
    slash_d = slash_q;
    len_d   = len_q;
    bits_d  = bits_q;
    ch_d    = ch_q;
    if (pop_o) begin
      busy_d  = 1'b1;
      slash_d = head_i.slash;
      len_d   = head_i.len;
      bits_d  = head_i.bits;
      ch_d    = head_i.ch;
    end else if (fire) begin
      priority if (final_beat) begin
        busy_d = 1'b0;
      end else if (slash_q) begin
        slash_d = 1'b0;
      end else begin
        len_d  = len_q - 3'd1;
        bits_d = {bits_q[3:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slash_q <= slash_d;
    len_q   <= len_d;
    bits_q  <= bits_d;
    ch_q    <= ch_d;
  end

endmodule
